>>> hw/rtl/hdp_pkg.sv
// Shared types, constants and helpers for the HID descriptor item parser.
// No dependencies; every other file in hw/rtl imports this package.
package hdp_pkg;

    // Collection nesting limit and the effective cap that fits nest_depth
    localparam int MAX_NESTING = 15;
    localparam int DEPTH_W     = 4;
    localparam int DEPTH_MAXV  = (1 << DEPTH_W) - 1;
    localparam logic [DEPTH_W-1:0] DEPTH_CAP =
        DEPTH_W'((MAX_NESTING < DEPTH_MAXV) ? MAX_NESTING : DEPTH_MAXV);

    // Prefix codes
    localparam logic [7:0] PFX_LONG      = 8'hfe;
    localparam logic [7:0] PFX_KIND_MASK = 8'hfc;
    localparam logic [7:0] PFX_END_COLL  = 8'hc0;
    localparam logic [7:0] PFX_COLL      = 8'ha0;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LONG  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef struct packed {
        logic [3:0]         item_tag;
        logic [1:0]         item_type;
        logic [2:0]         data_bytes;
        logic [31:0]        item_value;
        logic [DEPTH_W-1:0] nest_depth;
        logic [1:0]         item_status;
    } t_result;

    // Size code to data byte count: 0, 1, 2, 4
    function automatic logic [2:0] size_of(input logic [1:0] code);
        logic [2:0] n;
        case (code)
            2'd0:    n = 3'd0;
            2'd1:    n = 3'd1;
            2'd2:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/hdp_stream_if.sv
// Valid/ready channel interfaces for descriptor bytes and parsed items.
// Depends on hdp_pkg for the item depth width.
interface hdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] desc_byte;
    logic       desc_last;

    modport source (output valid, output desc_byte, output desc_last, input ready);
    modport sink   (input valid, input desc_byte, input desc_last, output ready);
endinterface

interface hdp_item_if;
    import hdp_pkg::*;
    logic               valid;
    logic               ready;
    logic [3:0]         item_tag;
    logic [1:0]         item_type;
    logic [2:0]         data_bytes;
    logic [31:0]        item_value;
    logic [DEPTH_W-1:0] nest_depth;
    logic [1:0]         item_status;

    modport source (output valid, output item_tag, output item_type, output data_bytes,
                    output item_value, output nest_depth, output item_status,
                    input ready);
    modport sink   (input valid, input item_tag, input item_type, input data_bytes,
                    input item_value, input nest_depth, input item_status,
                    output ready);
endinterface

>>> hw/rtl/hdp_parse_core.sv
// Parser state and per-byte step logic: prefix decode, data assembly, depth.
// Depends on hdp_pkg.
module hdp_parse_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_emit,
    output hdp_pkg::t_result o_result
);
    import hdp_pkg::*;

    logic [7:0]         r_prefix, n_prefix;
    logic [2:0]         r_left,   n_left;
    logic [1:0]         r_pos,    n_pos;
    logic [31:0]        r_accum,  n_accum;
    logic [DEPTH_W-1:0] r_depth,  n_depth;
    logic               r_halted, n_halted;

    logic               emit;
    logic [7:0]         e_prefix;
    logic [2:0]         e_nbytes;
    logic [31:0]        e_value;
    logic [1:0]         e_status;
    logic [31:0]        accum_new;
    logic [2:0]         left_dec;
    logic [2:0]         held_size;
    logic [2:0]         new_size;
    logic [7:0]         kind;
    logic [DEPTH_W-1:0] rep_depth;

    assign accum_new = r_accum | ({24'd0, i_byte} << {r_pos, 3'b000});
    assign left_dec  = r_left - 3'd1;
    assign held_size = size_of(r_prefix[1:0]);
    assign new_size  = size_of(i_byte[1:0]);

    always_comb begin
        n_prefix = r_prefix;
        n_left   = r_left;
        n_pos    = r_pos;
        n_accum  = r_accum;
        n_halted = r_halted;
        emit     = 1'b0;
        e_prefix = i_byte;
        e_nbytes = 3'd0;
        e_value  = 32'd0;
        e_status = ST_OK;

        if (!r_halted) begin
            if (r_left == 3'd0) begin
                if (i_byte == PFX_LONG) begin
                    emit     = 1'b1;
                    e_status = ST_LONG;
                    n_halted = 1'b1;
                end else if (new_size == 3'd0) begin
                    emit = 1'b1;
                end else begin
                    n_prefix = i_byte;
                    n_left   = new_size;
                    n_pos    = 2'd0;
                    n_accum  = 32'd0;
                    if (i_last) begin
                        emit     = 1'b1;
                        e_status = ST_TRUNC;
                    end
                end
            end else begin
                n_accum  = accum_new;
                n_pos    = r_pos + 2'd1;
                n_left   = left_dec;
                e_prefix = r_prefix;
                e_value  = accum_new;
                if (left_dec == 3'd0) begin
                    emit     = 1'b1;
                    e_nbytes = held_size;
                end else if (i_last) begin
                    emit     = 1'b1;
                    e_status = ST_TRUNC;
                    e_nbytes = held_size - left_dec;
                end
            end
        end

        // end collection lowers before the report, collection raises after
        kind      = e_prefix & PFX_KIND_MASK;
        rep_depth = r_depth;
        if (emit && kind == PFX_END_COLL && r_depth != '0) begin
            rep_depth = r_depth - DEPTH_W'(1);
        end
        n_depth = rep_depth;
        if (emit && kind == PFX_COLL && rep_depth < DEPTH_CAP) begin
            n_depth = rep_depth + DEPTH_W'(1);
        end

        // last byte: back to the reset state for the next descriptor
        if (i_last) begin
            n_prefix = 8'd0;
            n_left   = 3'd0;
            n_pos    = 2'd0;
            n_accum  = 32'd0;
            n_depth  = '0;
            n_halted = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 8'd0;
            r_left   <= 3'd0;
            r_pos    <= 2'd0;
            r_accum  <= 32'd0;
            r_depth  <= '0;
            r_halted <= 1'b0;
        end else if (i_step) begin
            r_prefix <= n_prefix;
            r_left   <= n_left;
            r_pos    <= n_pos;
            r_accum  <= n_accum;
            r_depth  <= n_depth;
            r_halted <= n_halted;
        end
    end

    assign o_emit               = i_step && emit;
    assign o_result.item_tag    = e_prefix[7:4];
    assign o_result.item_type   = e_prefix[3:2];
    assign o_result.data_bytes  = e_nbytes;
    assign o_result.item_value  = e_value;
    assign o_result.nest_depth  = rep_depth;
    assign o_result.item_status = e_status;

endmodule

>>> hw/rtl/hid_descriptor_item_parser.sv
// HID report descriptor short-item parser, top level.
// Depends on hdp_pkg, hdp_stream_if.sv (channel interfaces) and hdp_parse_core.
//
// Feed descriptor bytes on i_desc, one request per byte, with desc_last set
// on the final byte. Each completed short item yields one request on o_item
// with tag, type, data byte count, little-endian value, the collection depth
// used for the report, and status. End collection lowers the depth before
// it is reported, collection raises it afterwards; depth saturates at 0 and
// at the nesting cap. A long-item prefix (0xfe) reports long-item status and
// the rest of that descriptor is swallowed. If desc_last arrives mid-item a
// truncated status is reported with the bytes received so far. After the
// last byte the parser returns to its reset state, depth included.
// Throughput is one byte per cycle while o_item is not stalled: a byte is
// registered on entry, the parser consumes it in a single pass once the
// output register is free or being drained that cycle, and the result
// lands in an output register. The input stage accepts a byte whenever the
// input register is empty or its byte is being consumed that cycle.
module hid_descriptor_item_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hdp_byte_if.sink   i_desc,
    hdp_item_if.source o_item
);
    import hdp_pkg::*;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // output register
    logic       r_out_vld, n_out_vld;
    t_result    r_out;

    logic       out_free;
    logic       step;
    logic       in_acc;
    logic       emit;
    t_result    result;

    // parser consumes the held byte whenever the result slot can take a result
    assign out_free     = !r_out_vld || o_item.ready;
    assign step         = r_in_vld && out_free;
    assign i_desc.ready = !r_in_vld || step;
    assign in_acc       = i_desc.valid && i_desc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_desc.desc_byte;
            r_in_last <= i_desc.desc_last;
        end
    end

    hdp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_emit   (emit),
        .o_result (result)
    );

    // bytes that produce nothing just drain the slot if it is being taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (out_free) begin
            n_out_vld = emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_item.valid       = r_out_vld;
    assign o_item.item_tag    = r_out.item_tag;
    assign o_item.item_type   = r_out.item_type;
    assign o_item.data_bytes  = r_out.data_bytes;
    assign o_item.item_value  = r_out.item_value;
    assign o_item.nest_depth  = r_out.nest_depth;
    assign o_item.item_status = r_out.item_status;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for hid_descriptor_item_parser: directed and random descriptors.
// Depends on hdp_pkg, hdp_stream_if.sv and the parser RTL.
module testbench;
    import hdp_pkg::*;

    // Item type field codes
    localparam logic [1:0] TYPE_MAIN     = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL   = 2'd1;
    localparam logic [1:0] TYPE_LOCAL    = 2'd2;
    localparam logic [1:0] TYPE_RESERVED = 2'd3;

    // Size codes
    localparam logic [1:0] SZC_0B = 2'd0;
    localparam logic [1:0] SZC_1B = 2'd1;
    localparam logic [1:0] SZC_2B = 2'd2;
    localparam logic [1:0] SZC_4B = 2'd3;

    // Main item tags for collection and end collection
    localparam logic [3:0] TAG_COLLECTION = 4'ha;
    localparam logic [3:0] TAG_END_COLL   = 4'hc;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int BYTES_PER_PHASE = 300;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk;
    logic i_rst_n;

    hdp_byte_if desc_if ();
    hdp_item_if item_if ();

    hid_descriptor_item_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (desc_if),
        .o_item  (item_if)
    );

    // Idle percentages for the current phase
    int send_idle_pct;
    int stall_pct;
    int err_count;
    int cycle_count;

    // Predicted parser state
    logic [7:0]  pending_prefix;
    logic [2:0]  bytes_owed;
    logic [1:0]  byte_slot;
    logic [31:0] value_acc;
    logic [3:0]  depth_now;
    logic        swallowing;
    int          parsed_count;   // bytes that reached the parser while not swallowing

    t_result expected_items[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Data byte count for a size code
    function automatic logic [2:0] bytes_for_code(input logic [1:0] code);
        case (code)
            SZC_0B:  return 3'd0;
            SZC_1B:  return 3'd1;
            SZC_2B:  return 3'd2;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] make_prefix(input logic [3:0] tag, input logic [1:0] typ,
                                               input logic [1:0] szc);
        return {tag, typ, szc};
    endfunction

    task automatic clear_parse_state();
        pending_prefix = 8'h00;
        bytes_owed     = 3'd0;
        byte_slot      = 2'd0;
        value_acc      = 32'h0;
        depth_now      = 4'd0;
        swallowing     = 1'b0;
    endtask

    task automatic push_result(input logic [7:0] prefix, input logic [2:0] nbytes,
                               input logic [31:0] value, input logic [1:0] status);
        t_result r;
        r.item_tag    = prefix[7:4];
        r.item_type   = prefix[3:2];
        r.data_bytes  = nbytes;
        r.item_value  = value;
        r.nest_depth  = depth_now;
        r.item_status = status;
        expected_items.push_back(r);
    endtask

    // Short item report: end collection drops depth first, collection bumps it after
    task automatic report_item(input logic [7:0] prefix, input logic [2:0] nbytes,
                               input logic [31:0] value, input logic [1:0] status);
        logic [7:0] kind;
        kind = prefix & PFX_KIND_MASK;
        if (kind == PFX_END_COLL && depth_now != 0)
            depth_now = depth_now - 4'd1;
        push_result(prefix, nbytes, value, status);
        if (kind == PFX_COLL && depth_now < DEPTH_CAP)
            depth_now = depth_now + 4'd1;
    endtask

    // Advance the predicted state by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [2:0] full;
        if (!swallowing)
            parsed_count++;
        if (swallowing) begin
            // rest of the descriptor after a long item is dropped
        end else if (bytes_owed == 0) begin
            if (b == PFX_LONG) begin
                push_result(b, 3'd0, 32'h0, ST_LONG);
                swallowing = 1'b1;
            end else if (bytes_for_code(b[1:0]) == 0) begin
                report_item(b, 3'd0, 32'h0, ST_OK);
            end else begin
                pending_prefix = b;
                bytes_owed     = bytes_for_code(b[1:0]);
                byte_slot      = 2'd0;
                value_acc      = 32'h0;
                if (last)
                    report_item(b, 3'd0, 32'h0, ST_TRUNC);
            end
        end else begin
            full       = bytes_for_code(pending_prefix[1:0]);
            value_acc  = value_acc | (32'(b) << (8 * byte_slot));
            byte_slot  = byte_slot + 2'd1;
            bytes_owed = bytes_owed - 3'd1;
            if (bytes_owed == 0)
                report_item(pending_prefix, full, value_acc, ST_OK);
            else if (last)
                report_item(pending_prefix, full - bytes_owed, value_acc, ST_TRUNC);
        end
        if (last)
            clear_parse_state();
    endtask

    // Drive one byte request; inputs move on the falling edge only
    task automatic send_request(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            desc_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        desc_if.valid     <= 1'b1;
        desc_if.desc_byte <= b;
        desc_if.desc_last <= last;
        do
            @(posedge i_clk);
        while (!desc_if.ready);
        predict_byte(b, last);
    endtask

    task automatic send_descriptor(input t_byte_q bytes_q);
        foreach (bytes_q[i])
            send_request(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    // Prefix plus a random payload of the size its code asks for
    task automatic append_item(ref t_byte_q q, input logic [7:0] prefix);
        q.push_back(prefix);
        repeat (bytes_for_code(prefix[1:0]))
            q.push_back(8'($urandom_range(255)));
    endtask

    // Collections and end collections in 45 percent of picks, otherwise any short prefix
    function automatic logic [7:0] pick_prefix();
        int r;
        logic [7:0] p;
        r = $urandom_range(99);
        if (r < 25)
            return make_prefix(TAG_COLLECTION, TYPE_MAIN, 2'($urandom_range(3)));
        if (r < 45)
            return make_prefix(TAG_END_COLL, TYPE_MAIN, 2'($urandom_range(3)));
        do
            p = 8'($urandom_range(255));
        while (p == PFX_LONG);
        return p;
    endfunction

    // Every size code, every type, tag and data extremes
    task automatic test_short_items();
        t_byte_q q;
        q = {make_prefix(4'h0, TYPE_MAIN, SZC_0B),
             make_prefix(4'h8, TYPE_GLOBAL, SZC_1B), 8'hff,
             make_prefix(4'h1, TYPE_LOCAL, SZC_2B), 8'h00, 8'hff,
             make_prefix(4'hf, TYPE_RESERVED, SZC_4B), 8'h12, 8'h34, 8'h56, 8'hff,
             make_prefix(4'hf, TYPE_RESERVED, SZC_1B), 8'h80};
        send_descriptor(q);
    endtask

    // Depth floor at zero, raise after report, lower before report
    task automatic test_collection_depth();
        t_byte_q q;
        q = {make_prefix(TAG_END_COLL, TYPE_MAIN, SZC_0B),
             make_prefix(TAG_COLLECTION, TYPE_MAIN, SZC_0B),
             make_prefix(TAG_COLLECTION, TYPE_MAIN, SZC_1B), 8'h01,
             make_prefix(TAG_END_COLL, TYPE_MAIN, SZC_0B),
             make_prefix(TAG_END_COLL, TYPE_MAIN, SZC_1B), 8'h00};
        send_descriptor(q);
    endtask

    // Long item halts the descriptor; the next descriptor starts clean
    task automatic test_long_item();
        t_byte_q q;
        q = {make_prefix(TAG_COLLECTION, TYPE_MAIN, SZC_0B), PFX_LONG, 8'h05, 8'h09,
             make_prefix(TAG_END_COLL, TYPE_MAIN, SZC_0B)};
        send_descriptor(q);
        q = {make_prefix(4'h0, TYPE_GLOBAL, SZC_0B)};
        send_descriptor(q);
    endtask

    // Last flag on a bare prefix and in the middle of the data
    task automatic test_truncation();
        t_byte_q q;
        q = {make_prefix(4'h0, TYPE_MAIN, SZC_4B)};
        send_descriptor(q);
        q = {make_prefix(TAG_COLLECTION, TYPE_MAIN, SZC_0B),
             make_prefix(TAG_END_COLL, TYPE_MAIN, SZC_4B), 8'h11, 8'h22, 8'h33};
        send_descriptor(q);
        q = {make_prefix(4'h2, TYPE_LOCAL, SZC_2B), 8'h7f};
        send_descriptor(q);
    endtask

    // Nest past the cap, then unwind past zero
    task automatic test_nesting_limits();
        t_byte_q q;
        q = {};
        repeat (int'(DEPTH_CAP) + $urandom_range(1, 5))
            append_item(q, make_prefix(TAG_COLLECTION, TYPE_MAIN, 2'($urandom_range(3))));
        append_item(q, pick_prefix());
        repeat (int'(DEPTH_CAP) + $urandom_range(1, 5))
            append_item(q, make_prefix(TAG_END_COLL, TYPE_MAIN, 2'($urandom_range(3))));
        send_descriptor(q);
    endtask

    // Mostly well-formed descriptors; some end cut short, hit a long item, or are noise
    task automatic test_random_stream(input int n_bytes);
        t_byte_q q;
        int start;
        int mode;
        logic [7:0] p;
        start = parsed_count;
        while (parsed_count - start < n_bytes) begin
            q = {};
            mode = $urandom_range(99);
            repeat ($urandom_range(1, 10))
                append_item(q, pick_prefix());
            if (mode < 15) begin
                p = pick_prefix();
                if (p[1:0] == SZC_0B)
                    p[1:0] = 2'($urandom_range(1, 3));
                q.push_back(p);
                repeat ($urandom_range(0, bytes_for_code(p[1:0]) - 1))
                    q.push_back(8'($urandom_range(255)));
            end else if (mode < 25) begin
                q.push_back(PFX_LONG);
                repeat ($urandom_range(0, 4))
                    q.push_back(8'($urandom_range(255)));
            end else if (mode < 32) begin
                repeat ($urandom_range(1, 8))
                    q.push_back(8'($urandom_range(255)));
            end
            send_descriptor(q);
        end
    endtask

    // Result receiver stalls at random
    initial begin
        item_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            item_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && item_if.valid && item_if.ready) begin
            if (expected_items.size() == 0) begin
                $error("unexpected item: tag %0h type %0d", item_if.item_tag,
                       item_if.item_type);
                err_count++;
            end else begin
                exp_r = expected_items.pop_front();
                if (item_if.item_tag !== exp_r.item_tag) begin
                    $error("item_tag expected %0h got %0h", exp_r.item_tag, item_if.item_tag);
                    err_count++;
                end
                if (item_if.item_type !== exp_r.item_type) begin
                    $error("item_type expected %0d got %0d", exp_r.item_type,
                           item_if.item_type);
                    err_count++;
                end
                if (item_if.data_bytes !== exp_r.data_bytes) begin
                    $error("data_bytes expected %0d got %0d", exp_r.data_bytes,
                           item_if.data_bytes);
                    err_count++;
                end
                if (item_if.item_value !== exp_r.item_value) begin
                    $error("item_value expected %h got %h", exp_r.item_value,
                           item_if.item_value);
                    err_count++;
                end
                if (item_if.nest_depth !== exp_r.nest_depth) begin
                    $error("nest_depth expected %0d got %0d", exp_r.nest_depth,
                           item_if.nest_depth);
                    err_count++;
                end
                if (item_if.item_status !== exp_r.item_status) begin
                    $error("item_status expected %0d got %0d", exp_r.item_status,
                           item_if.item_status);
                    err_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        desc_if.valid     = 1'b0;
        desc_if.desc_byte = 8'h00;
        desc_if.desc_last = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        err_count         = 0;
        cycle_count       = 0;
        parsed_count      = 0;
        clear_parse_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_items();
        test_collection_depth();
        test_long_item();
        test_truncation();

        // no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 72 : (phase == 3) ? 24 : 0;
            stall_pct     = (phase == 2) ? 72 : (phase == 3) ? 24 : 0;
            test_nesting_limits();
            test_random_stream(BYTES_PER_PHASE);
        end

        @(negedge i_clk);
        desc_if.valid <= 1'b0;
        while (expected_items.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
